// ===== hdl/kwsm_pkg.sv =====
// Shared types and constants for the k-way stream merge.
package kwsm_pkg;

  localparam int NUM_SOURCES = 8;
  localparam int TAG_WIDTH   = 32;

  localparam int SOURCE_W    = 3;
  localparam int INDEX_W     = 64;
  localparam int TAG_IN_W    = 32;
  localparam int TAG_STORE_W = (TAG_WIDTH < TAG_IN_W) ? TAG_WIDTH : TAG_IN_W;
  localparam int CLOG_SRC    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int ID_W        = (CLOG_SRC > SOURCE_W) ? CLOG_SRC : SOURCE_W;
  localparam int CNT_W       = CLOG_SRC;

  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 104;

  // Kind of input word, carried on the input tuser.
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_POP  = 1'b1
  } word_mode_t;

  // Best head seen so far as it moves down the row of cells.
  typedef struct packed {
    logic                   found;
    logic [SOURCE_W-1:0]    src;
    logic [INDEX_W-1:0]     index;
    logic [TAG_STORE_W-1:0] tag;
  } cand_t;

  // Load and clear requests broadcast to all cells.
  typedef struct packed {
    logic                   load;
    logic                   ended;
    logic [SOURCE_W-1:0]    src;
    logic [INDEX_W-1:0]     index;
    logic [TAG_STORE_W-1:0] tag;
    logic                   clr;
    logic [SOURCE_W-1:0]    clr_src;
  } cell_cmd_t;

endpackage

// ===== hdl/k_way_stream_merge_by_index.sv =====
// A load word (tuser 0) writes or ends one source head. A pop word (tuser 1) is taken
// and the input then stalls while the smallest valid head ripples down a row of
// NUM_SOURCES cells, one cell per cycle: a scan counter steps to the last cell, the
// result is captured once the output register is free, and the next word is taken in
// the cycle after the capture. Ties go to the lower source number, and a pop with no
// valid head returns a word with found (tuser) low and zero fields.
// The result sits in an output register, so loads keep flowing while it waits.
module k_way_stream_merge_by_index (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // source[2:0], ended[3], slice_index[67:4], payload_tag[99:68], zero pad
  input  logic [kwsm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // from_source[2:0], popped_index[66:3], popped_tag[98:67], zero pad
  output logic [kwsm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // found
  output logic                            m_axis_tuser
);
  import kwsm_pkg::*;

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic                   in_fire;
  logic                   capture;
  cell_cmd_t              cmd;
  cand_t                  chain [NUM_SOURCES+1];
  logic [NUM_SOURCES-1:0] valid_vec;
  logic                   res_found;
  logic [SOURCE_W-1:0]    res_src;
  logic [INDEX_W-1:0]     res_index;
  logic [TAG_STORE_W-1:0] res_tag;

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign capture       = busy && (cnt == CNT_W'(NUM_SOURCES - 1))
                         && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    cmd.load    = in_fire && (s_axis_tuser == MODE_LOAD);
    cmd.src     = s_axis_tdata[2:0];
    cmd.ended   = s_axis_tdata[3];
    cmd.index   = s_axis_tdata[67:4];
    cmd.tag     = s_axis_tdata[68 +: TAG_STORE_W];
    cmd.clr     = capture && chain[NUM_SOURCES].found;
    cmd.clr_src = chain[NUM_SOURCES].src;
  end

  assign chain[0] = '0;

  for (genvar k = 0; k < NUM_SOURCES; k++) begin : g_cell
    kwsm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (ID_W'(k)),
      .cmd      (cmd),
      .cand_in  (chain[k]),
      .cand_out (chain[k+1]),
      .valid    (valid_vec[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (capture) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_fire && (s_axis_tuser == MODE_POP)) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (capture) begin
        busy <= 1'b0;
      end else if (busy && (cnt != CNT_W'(NUM_SOURCES - 1))) begin
        cnt <= cnt + 1'b1;
      end
    end
    if (capture) begin
      res_found <= chain[NUM_SOURCES].found;
      res_src   <= chain[NUM_SOURCES].src;
      res_index <= chain[NUM_SOURCES].index;
      res_tag   <= chain[NUM_SOURCES].tag;
    end
  end

  assign m_axis_tuser = res_found;
  assign m_axis_tdata = {5'b0, TAG_IN_W'(res_tag), res_index, res_src};

  // A result only appears at the end of a scan.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(busy))
    else $error("result word without a completed scan");

  // Popping a found head retires exactly one valid entry.
  assert property (@(posedge clk) disable iff (rst)
    (capture && chain[NUM_SOURCES].found) |=>
      ($countones(valid_vec) == $past($countones(valid_vec)) - 1))
    else $error("pop did not clear the winning head");

  // The scan counter stops at the end of the row.
  assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= CNT_W'(NUM_SOURCES - 1)))
    else $error("scan counter ran past the last cell");

endmodule

// ===== hdl/kwsm_cell.sv =====
// One head entry of the merge row: stores a source head and passes on the smaller candidate.
module kwsm_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [kwsm_pkg::ID_W-1:0] cell_id,
  input  kwsm_pkg::cell_cmd_t    cmd,
  input  kwsm_pkg::cand_t        cand_in,
  output kwsm_pkg::cand_t        cand_out,
  output logic                   valid
);
  import kwsm_pkg::*;

  logic [INDEX_W-1:0]     index;
  logic [TAG_STORE_W-1:0] tag;
  logic                   load_hit;
  logic                   clr_hit;
  logic                   take_own;
  cand_t                  cand_next;

  assign load_hit = cmd.load && (ID_W'(cmd.src) == cell_id);
  assign clr_hit  = cmd.clr && (ID_W'(cmd.clr_src) == cell_id);

  // Strict compare keeps the lower-numbered source on equal indices.
  assign take_own = valid && (!cand_in.found || (index < cand_in.index));

  always_comb begin
    cand_next = cand_in;
    if (take_own) begin
      cand_next.found = 1'b1;
      cand_next.src   = cell_id[SOURCE_W-1:0];
      cand_next.index = index;
      cand_next.tag   = tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      cand_out.found <= 1'b0;
    end else begin
      if (load_hit) begin
        valid <= !cmd.ended;
      end else if (clr_hit) begin
        valid <= 1'b0;
      end
      cand_out.found <= cand_next.found;
    end
    if (load_hit && !cmd.ended) begin
      index <= cmd.index;
      tag   <= cmd.tag;
    end
    cand_out.src   <= cand_next.src;
    cand_out.index <= cand_next.index;
    cand_out.tag   <= cand_next.tag;
  end

endmodule
